// ===== design/hsl_color_adjust_assert.svh =====
// Assertion macros for the port-level checker.
`ifndef HSL_COLOR_ADJUST_ASSERT_SVH
`define HSL_COLOR_ADJUST_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define HSLCA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hsl_color_adjust: assertion failed");

// Next-cycle implication, quiet during reset.
`define HSLCA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hsl_color_adjust: assertion failed");

// Next-cycle implication that also holds across reset.
`define HSLCA_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("hsl_color_adjust: assertion failed");

`endif

// ===== design/hslca_pkg.sv =====
// Shared types and codes for the HSL color adjust block.
package hslca_pkg;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
  } pix_out_t;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_AMOUNT = 2'd1;
  localparam logic [1:0] REG_ALPHA  = 2'd2;

  // Adjust modes.
  localparam logic [1:0] MODE_LIGHTEN    = 2'd0;
  localparam logic [1:0] MODE_DARKEN     = 2'd1;
  localparam logic [1:0] MODE_DESATURATE = 2'd2;
  localparam logic [1:0] MODE_SET_ALPHA  = 2'd3;

  // Hue base sector of the max channel, in sixths of a turn.
  localparam logic [2:0] BASE_RED   = 3'd0;
  localparam logic [2:0] BASE_GREEN = 3'd2;
  localparam logic [2:0] BASE_BLUE  = 3'd4;

  // Per-channel segment of the back conversion.
  localparam logic [1:0] SEG_RAMP = 2'd0;
  localparam logic [1:0] SEG_HIGH = 2'd1;
  localparam logic [1:0] SEG_LOW  = 2'd2;

  // Sideband carried alongside the math.
  typedef struct packed {
    logic       pass;
    logic       hue_neg;
    logic [2:0] hue_base;
    pix_in_t    pix;
  } side_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] alpha_value;
  } cfg_t;

endpackage

// ===== design/hslca_rdiv.sv =====
// Three-stage rounded divider: reciprocal multiply, then one correction step.
module hslca_rdiv import hslca_pkg::*; #(
  parameter int NW = 25,
  parameter int DW = 9,
  parameter int RW = 33,
  parameter int K  = 32,
  parameter int QW = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] dvs,
  input  logic [RW-1:0] recip,
  output logic [QW-1:0] quo
);

  logic [NW+RW-1:0] prod_a;
  logic [NW-1:0]    num_a, num_b;
  logic [DW-1:0]    dvs_a, dvs_b;
  logic [QW-1:0]    q0, q_b;
  logic [QW+DW-1:0] qd_b;
  logic [NW-1:0]    rem;

  assign q0  = QW'(prod_a >> K);
  assign rem = num_b - NW'(qd_b);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_a <= (NW+RW)'(num) * (NW+RW)'(recip);
      num_a  <= num;
      dvs_a  <= dvs;
      qd_b   <= (QW+DW)'(q0) * (QW+DW)'(dvs_a);
      q_b    <= q0;
      num_b  <= num_a;
      dvs_b  <= dvs_a;
      // estimate is low by at most one
      quo    <= q_b + QW'(rem >= NW'(dvs_b));
    end
  end

endmodule

// ===== design/hslca_rgb2hsl.sv =====
// Forward conversion: RGB to lightness, saturation and hue term.
module hslca_rgb2hsl import hslca_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  pix_in_t            in_pix,
  input  logic [1:0]         mode,
  output logic               out_valid,
  output side_t              out_side,
  output logic [FRAC_BITS:0] lum,
  output logic [FRAC_BITS:0] sat,
  output logic [FRAC_BITS:0] hterm
);

  localparam int F  = FRAC_BITS;
  localparam int NW = F + 9;
  localparam int K  = F + 16;
  localparam int RW = K + 1;
  localparam int QW = F + 1;
  localparam logic [RW-1:0] RECIP_510 = RW'((65'd1 << K) / 65'd510);

  logic [RW-1:0] recip_tab [256];

  assign recip_tab[0] = '0;
  for (genvar i = 1; i < 256; i++) begin : g_recip
    localparam logic [RW-1:0] RV = RW'((65'd1 << K) / 65'(i));
    assign recip_tab[i] = RV;
  end

  // stage 1 comb
  logic [7:0] r, g, b, mx, mn, ha, hb, dd, den;
  logic [8:0] sum;
  logic [2:0] base;

  always_comb begin
    r  = in_pix.red_in;
    g  = in_pix.green_in;
    b  = in_pix.blue_in;
    mx = (r > g) ? r : g;
    if (b > mx) mx = b;
    mn = (r < g) ? r : g;
    if (b < mn) mn = b;
    sum = {1'b0, mx} + {1'b0, mn};
    dd  = mx - mn;
    priority if (mx == r) begin
      base = BASE_RED;  ha = g; hb = b;
    end else if (mx == g) begin
      base = BASE_GREEN; ha = b; hb = r;
    end else begin
      base = BASE_BLUE; ha = r; hb = g;
    end
    den = (sum > 9'd255) ? 8'(9'd510 - sum) : sum[7:0];
    if (den == 8'd0) den = 8'd1;
  end

  logic        v1, v2;
  side_t       side1, side2;
  logic [8:0]  sum1;
  logic [7:0]  d1, den1, mag1;
  logic [NW-1:0] nl2, ns2, nh2;
  logic [RW-1:0] rs2, rh2;
  logic [7:0]  den2, d2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum1          <= sum;
      d1            <= dd;
      den1          <= den;
      mag1          <= (ha < hb) ? hb - ha : ha - hb;
      side1.pass    <= (mode == MODE_SET_ALPHA);
      side1.hue_neg <= (ha < hb);
      side1.hue_base <= base;
      side1.pix     <= in_pix;
      // a zero spread gives zero terms; the hue divisor is forced to one
      nl2  <= NW'({sum1, {F{1'b0}}}) + NW'(9'd255);
      ns2  <= NW'({d1, {F{1'b0}}}) + NW'(den1 >> 1);
      nh2  <= NW'({mag1, {F{1'b0}}}) + NW'(d1 >> 1);
      rs2  <= recip_tab[den1];
      rh2  <= recip_tab[(d1 == 8'd0) ? 8'd1 : d1];
      den2 <= den1;
      d2   <= (d1 == 8'd0) ? 8'd1 : d1;
      side2 <= side1;
    end
  end

  hslca_rdiv #(.NW(NW), .DW(9), .RW(RW), .K(K), .QW(QW)) u_div_l (
    .clk(clk), .en(en), .num(nl2), .dvs(9'd510), .recip(RECIP_510), .quo(lum)
  );
  hslca_rdiv #(.NW(NW), .DW(9), .RW(RW), .K(K), .QW(QW)) u_div_s (
    .clk(clk), .en(en), .num(ns2), .dvs({1'b0, den2}), .recip(rs2), .quo(sat)
  );
  hslca_rdiv #(.NW(NW), .DW(9), .RW(RW), .K(K), .QW(QW)) u_div_h (
    .clk(clk), .en(en), .num(nh2), .dvs({1'b0, d2}), .recip(rh2), .quo(hterm)
  );

  // match the divider latency
  logic  vd [3];
  side_t sd [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) vd[i] <= 1'b0;
    end else if (en) begin
      vd[0] <= v2;
      for (int i = 1; i < 3; i++) vd[i] <= vd[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= side2;
      for (int i = 1; i < 3; i++) sd[i] <= sd[i-1];
    end
  end

  assign out_valid = vd[2];
  assign out_side  = sd[2];

endmodule

// ===== design/hslca_hsl2rgb.sv =====
// Adjust and back conversion: HSL to RGB bytes, plus the set-alpha path.
module hslca_hsl2rgb import hslca_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  side_t              in_side,
  input  logic [FRAC_BITS:0] lum,
  input  logic [FRAC_BITS:0] sat,
  input  logic [FRAC_BITS:0] hterm,
  input  cfg_t               cfg,
  input  logic [16:0]        amount,
  output logic               out_valid,
  output pix_out_t           out_pix
);

  localparam int F  = FRAC_BITS;
  localparam int AW = F + 2;
  localparam int SW = F + 4;
  localparam logic [F+2:0] ONE  = (F+3)'(1) << F;
  localparam logic [F+2:0] SIX  = (F+3)'(6) << F;
  localparam logic [F+2:0] TWO  = (F+3)'(2) << F;
  localparam logic [F+2:0] THR  = (F+3)'(3) << F;
  localparam logic [F+2:0] FOUR = (F+3)'(4) << F;
  localparam logic [F:0]   HALF = (F+1)'(1) << (F - 1);

  // amount at F fraction bits
  logic [AW-1:0] amt;
  if (FRAC_BITS >= 16) begin : g_amt_up
    assign amt = AW'(amount) << (F - 16);
  end else begin : g_amt_dn
    logic [17:0] amt_r;
    assign amt_r = {1'b0, amount} + 18'(18'd1 << (15 - F));
    assign amt   = AW'(amt_r >> (16 - F));
  end

  // stage 6 comb: adjust, clamp, hue
  logic signed [SW-1:0] adj, hue;
  logic [F:0]   l6n, s6n;
  logic [F+2:0] h6n;

  always_comb begin
    unique case (cfg.mode)
      MODE_LIGHTEN: adj = $signed(SW'(lum)) + $signed(SW'(amt));
      MODE_DARKEN:  adj = $signed(SW'(lum)) - $signed(SW'(amt));
      default:      adj = $signed(SW'(sat)) - $signed(SW'(amt));
    endcase
    l6n = lum;
    s6n = sat;
    if (cfg.mode == MODE_DESATURATE) begin
      s6n = (adj < 0) ? '0 : (adj > $signed(SW'(ONE))) ? ONE[F:0] : (F+1)'(adj);
    end else begin
      l6n = (adj < 0) ? '0 : (adj > $signed(SW'(ONE))) ? ONE[F:0] : (F+1)'(adj);
    end
    hue = $signed(SW'({in_side.hue_base, {F{1'b0}}}));
    hue = in_side.hue_neg ? hue - $signed(SW'(hterm)) : hue + $signed(SW'(hterm));
    if (hue < 0) hue = hue + $signed(SW'(SIX));
    if (hue >= $signed(SW'(SIX))) hue = hue - $signed(SW'(SIX));
    h6n = (F+3)'(hue);
  end

  logic [F:0]     l6, s6, l7, s7;
  logic [F+2:0]   h6, h7;
  logic           lo7;
  logic [2*F+2:0] m7;

  // stage 8 comb
  logic [F+1:0] rr, q8n;
  logic signed [F+3:0] pd;
  logic [F:0]   p8n;
  logic [F+1:0] span8n;
  logic [F+2:0] t [3];
  logic [F:0]   f8n [3];
  logic [1:0]   seg8n [3];

  always_comb begin
    rr  = (F+2)'((m7 + (2*F+3)'(HALF)) >> F);
    q8n = lo7 ? rr : (F+2)'(l7) + (F+2)'(s7) - rr;
    pd  = $signed((F+4)'({l7, 1'b0})) - $signed((F+4)'(q8n));
    p8n = (pd < 0) ? '0 : (F+1)'(pd);
    span8n = (q8n > (F+2)'(p8n)) ? q8n - (F+2)'(p8n) : '0;
    t[0] = (h7 + TWO >= SIX) ? h7 + TWO - SIX : h7 + TWO;
    t[1] = h7;
    t[2] = (h7 >= TWO) ? h7 - TWO : h7 + FOUR;
    for (int i = 0; i < 3; i++) begin
      f8n[i] = '0;
      priority if (t[i] < ONE) begin
        seg8n[i] = SEG_RAMP;
        f8n[i]   = (F+1)'(t[i]);
      end else if (t[i] < THR) begin
        seg8n[i] = SEG_HIGH;
      end else if (t[i] < FOUR) begin
        seg8n[i] = SEG_RAMP;
        f8n[i]   = (F+1)'(FOUR - t[i]);
      end else begin
        seg8n[i] = SEG_LOW;
      end
    end
  end

  logic [F:0]     p8, p9;
  logic [F+1:0]   q8, q9, span8;
  logic [F:0]     f8 [3];
  logic [1:0]     seg8 [3], seg9 [3];
  logic [2*F+2:0] prod9 [3];

  // stage 10 comb
  logic [F+1:0]  v [3];
  logic [F+11:0] w [3];
  logic [F+11:0] bw [3];
  logic [7:0]    byt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unique case (seg9[i])
        SEG_RAMP: v[i] = (F+2)'(p9) + (F+2)'((prod9[i] + (2*F+3)'(HALF)) >> F);
        SEG_HIGH: v[i] = q9;
        default:  v[i] = (F+2)'(p9);
      endcase
      w[i]   = ((F+12)'(v[i]) << 8) - (F+12)'(v[i]);
      bw[i]  = (w[i] + (F+12)'(HALF)) >> F;
      byt[i] = (bw[i] > (F+12)'(255)) ? 8'd255 : bw[i][7:0];
    end
  end

  logic  vp [5];
  side_t sp [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 5; i++) vp[i] <= 1'b0;
    end else if (en) begin
      vp[0] <= in_valid;
      for (int i = 1; i < 5; i++) vp[i] <= vp[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sp[0] <= in_side;
      for (int i = 1; i < 4; i++) sp[i] <= sp[i-1];
      l6 <= l6n;
      s6 <= s6n;
      h6 <= h6n;
      lo7 <= (l6 < HALF);
      m7  <= (2*F+3)'(l6) * (2*F+3)'((l6 < HALF) ? ONE[F+1:0] + (F+2)'(s6) : (F+2)'(s6));
      l7  <= l6;
      s7  <= s6;
      h7  <= h6;
      p8  <= p8n;
      q8  <= q8n;
      span8 <= span8n;
      for (int i = 0; i < 3; i++) begin
        f8[i]    <= f8n[i];
        seg8[i]  <= seg8n[i];
        prod9[i] <= (2*F+3)'(span8) * (2*F+3)'(f8[i]);
        seg9[i]  <= seg8[i];
      end
      p9 <= p8;
      q9 <= q8;
      if (sp[3].pass) begin
        out_pix.red_out   <= sp[3].pix.red_in;
        out_pix.green_out <= sp[3].pix.green_in;
        out_pix.blue_out  <= sp[3].pix.blue_in;
        out_pix.alpha_out <= cfg.alpha_value;
      end else begin
        out_pix.red_out   <= byt[0];
        out_pix.green_out <= byt[1];
        out_pix.blue_out  <= byt[2];
        out_pix.alpha_out <= sp[3].pix.alpha_in;
      end
    end
  end

  assign out_valid = vp[4];

endmodule

// ===== design/hsl_color_adjust.sv =====
// Top level of the HSL color adjust pipeline.
// Usage:
//   src_valid/src_stall/src_data carry one RGBA pixel per beat; dst_valid/
//   dst_stall/dst_data carry the adjusted pixel. A beat moves on a rising
//   edge with valid high and stall low.
//   Write mode, amount and alpha_value through cfg_we/cfg_index/cfg_data
//   only while no pixel is in flight.
//   Throughput: one pixel per clock while dst_stall does not hold the
//   pipe; the depth is set by the reciprocal dividers (three stages) and
//   the two multiplier stages of the back conversion.
//   All stages share one enable: when dst_valid is held by dst_stall the
//   whole pipe freezes and src_stall rises in the same cycle; no beat is
//   lost or repeated.
//   Reset clears every valid bit and loads mode lighten, amount zero and
//   alpha_value 255.
module hsl_color_adjust import hslca_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        src_valid,
  output logic        src_stall,
  input  pix_in_t     src_data,
  output logic        dst_valid,
  input  logic        dst_stall,
  output pix_out_t    dst_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  cfg_t        cfg;
  logic [16:0] amount;
  logic        en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode        <= MODE_LIGHTEN;
      cfg.alpha_value <= 8'd255;
      amount          <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:   cfg.mode        <= cfg_data[1:0];
        REG_AMOUNT: amount          <= cfg_data;
        REG_ALPHA:  cfg.alpha_value <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign en        = !(dst_valid && dst_stall);
  assign src_stall = !en;

  logic               hv;
  side_t              hside;
  logic [FRAC_BITS:0] lum, sat, hterm;

  hslca_rgb2hsl #(.FRAC_BITS(FRAC_BITS)) u_fwd (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(src_valid), .in_pix(src_data), .mode(cfg.mode),
    .out_valid(hv), .out_side(hside), .lum(lum), .sat(sat), .hterm(hterm)
  );

  hslca_hsl2rgb #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(hv), .in_side(hside), .lum(lum), .sat(sat), .hterm(hterm),
    .cfg(cfg), .amount(amount),
    .out_valid(dst_valid), .out_pix(dst_data)
  );

endmodule

// ===== design/hslca_chk.sv =====
// Port-level checker for the HSL color adjust block, bound to the top level.
`include "hsl_color_adjust_assert.svh"

module hslca_chk import hslca_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     src_valid,
  input logic     src_stall,
  input logic     dst_valid,
  input logic     dst_stall,
  input pix_out_t dst_data
);

  `HSLCA_ASSERT_NEXT(a_dst_hold, dst_valid && dst_stall, dst_valid && $stable(dst_data))
  `HSLCA_ASSERT_NOW(a_stall_cause, src_stall, dst_valid && dst_stall)
  `HSLCA_ASSERT_NOW(a_empty_open, !dst_valid, !src_stall)
  `HSLCA_ASSERT_RST(a_reset_empty, rst, !dst_valid)

endmodule

bind hsl_color_adjust hslca_chk u_chk (.*);

// ===== tb/sv/tb_top.sv =====
// Testbench for the HSL color adjust pipeline: predicted pixels checked against the outputs.
`timescale 1ns / 1ps

module tb_top;
  import hslca_pkg::*;

  localparam int FB = 16;
  localparam longint ONE = 64'sd1 <<< FB;
  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic src_valid = 1'b0;
  logic src_stall;
  pix_in_t src_data = '0;
  logic dst_valid;
  logic dst_stall = 1'b0;
  pix_out_t dst_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [16:0] cfg_data = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  hsl_color_adjust #(.FRAC_BITS(FB)) DUT (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_stall(src_stall), .src_data(src_data),
    .dst_valid(dst_valid), .dst_stall(dst_stall), .dst_data(dst_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic longint div_round(longint n, longint d);
    if (d <= 0 || n < 0) return 0;
    return (n + d / 2) / d;
  endfunction

  function automatic longint hue_offset(longint a, longint b, longint d);
    if (a >= b) return div_round((a - b) * ONE, d);
    return -div_round((b - a) * ONE, d);
  endfunction

  function automatic longint channel_level(longint p, longint q, longint t);
    longint span;
    span = q - p;
    t = t % (6 * ONE);
    if (t < 0) t += 6 * ONE;
    if (span < 0) span = 0;
    if (t < ONE) return p + ((span * t + ONE / 2) >>> FB);
    if (t < 3 * ONE) return q;
    if (t < 4 * ONE) return p + ((span * (4 * ONE - t) + ONE / 2) >>> FB);
    return p;
  endfunction

  function automatic logic [7:0] level_byte(longint v);
    longint b;
    if (v < 0) v = 0;
    b = (v * 255 + ONE / 2) >>> FB;
    if (b > 255) b = 255;
    return b[7:0];
  endfunction

  function automatic longint unit_clamp(longint v);
    if (v < 0) return 0;
    if (v > ONE) return ONE;
    return v;
  endfunction

  class pixel_board;
    logic [1:0] mode = MODE_LIGHTEN;
    logic [16:0] amount = '0;
    logic [7:0] alpha_value = 8'd255;
    pix_out_t pending[$];
    int errors = 0;
    int checked = 0;

    function pix_out_t adjust(pix_in_t px);
      pix_out_t o;
      longint r, g, b, mx, mn, sum, d, lum, sat, hue, q, p;
      r = px.red_in; g = px.green_in; b = px.blue_in;
      o.alpha_out = px.alpha_in;
      if (mode == MODE_SET_ALPHA) begin
        o.red_out = px.red_in; o.green_out = px.green_in; o.blue_out = px.blue_in;
        o.alpha_out = alpha_value;
        return o;
      end
      mx = (r > g) ? r : g; if (b > mx) mx = b;
      mn = (r < g) ? r : g; if (b < mn) mn = b;
      sum = mx + mn; d = mx - mn;
      lum = div_round(sum * ONE, 510);
      sat = 0; hue = 0;
      if (d != 0) begin
        sat = (sum > 255) ? div_round(d * ONE, 510 - sum) : div_round(d * ONE, sum);
        if (mx == r) hue = hue_offset(g, b, d);
        else if (mx == g) hue = 2 * ONE + hue_offset(b, r, d);
        else hue = 4 * ONE + hue_offset(r, g, d);
        if (hue < 0) hue += 6 * ONE;
        if (hue >= 6 * ONE) hue -= 6 * ONE;
      end
      case (mode)
        MODE_LIGHTEN: lum = unit_clamp(lum + longint'(amount));
        MODE_DARKEN: lum = unit_clamp(lum - longint'(amount));
        default: sat = unit_clamp(sat - longint'(amount));
      endcase
      if (sat == 0) begin
        o.red_out = level_byte(lum); o.green_out = o.red_out; o.blue_out = o.red_out;
      end else begin
        if (lum < ONE / 2) q = (lum * (ONE + sat) + ONE / 2) >>> FB;
        else q = lum + sat - ((lum * sat + ONE / 2) >>> FB);
        p = 2 * lum - q;
        if (p < 0) p = 0;
        o.red_out = level_byte(channel_level(p, q, hue + 2 * ONE));
        o.green_out = level_byte(channel_level(p, q, hue));
        o.blue_out = level_byte(channel_level(p, q, hue - 2 * ONE));
      end
      return o;
    endfunction

    function void note_pixel(pix_in_t px);
      pending.push_back(adjust(px));
    endfunction

    function void check_pixel(pix_out_t got);
      pix_out_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected pixel %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.red_out !== want.red_out)
        $display("%0t: red expected %0d actual %0d", $time, want.red_out, got.red_out);
      if (got.green_out !== want.green_out)
        $display("%0t: green expected %0d actual %0d", $time, want.green_out, got.green_out);
      if (got.blue_out !== want.blue_out)
        $display("%0t: blue expected %0d actual %0d", $time, want.blue_out, got.blue_out);
      if (got.alpha_out !== want.alpha_out)
        $display("%0t: alpha expected %0d actual %0d", $time, want.alpha_out, got.alpha_out);
      if (got !== want) errors++;
    endfunction
  endclass

  pixel_board board = new();
  int src_idle_pct = 33;
  int dst_idle_pct = 33;
  int hold_cycles = 0;
  int cycles = 0;

  // Sample both channels on the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (src_valid && !src_stall) board.note_pixel(src_data);
      if (dst_valid && !dst_stall) board.check_pixel(dst_data);
    end
  end

  // Receiver stall: long hold-off when requested, otherwise random.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      dst_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      dst_stall <= ($urandom_range(99) < dst_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic send_pixel(pix_in_t px);
    while ($urandom_range(99) < src_idle_pct) begin
      src_valid <= 1'b0;
      @(negedge clk);
    end
    src_valid <= 1'b1;
    src_data <= px;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_burst(pix_in_t px);
    // Keep valid high across back-to-back beats.
    src_valid <= 1'b1;
    src_data <= px;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain;
    src_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (14) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [16:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MODE: board.mode = val[1:0];
      REG_AMOUNT: board.amount = val;
      default: board.alpha_value = val[7:0];
    endcase
    @(negedge clk);
  endtask

  function automatic pix_in_t rand_pixel();
    pix_in_t px;
    px = $urandom;
    case ($urandom_range(7))
      0: begin px.green_in = px.red_in; px.blue_in = px.red_in; end
      1: px.blue_in = px.red_in;
      2: px.green_in = px.red_in;
      default: ;
    endcase
    return px;
  endfunction

  function automatic logic [16:0] rand_amount();
    case ($urandom_range(5))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'h1FFFF;
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  pix_in_t directed[$];
  int phase;

  initial begin
    directed = '{
      {8'd0, 8'd0, 8'd0, 8'd0}, {8'd255, 8'd255, 8'd255, 8'd255},
      {8'd128, 8'd128, 8'd128, 8'd77}, {8'd255, 8'd0, 8'd0, 8'd1},
      {8'd0, 8'd255, 8'd0, 8'd2}, {8'd0, 8'd0, 8'd255, 8'd3},
      {8'd255, 8'd255, 8'd0, 8'd128}, {8'd0, 8'd255, 8'd255, 8'd254},
      {8'd255, 8'd0, 8'd255, 8'd170}, {8'd200, 8'd100, 8'd150, 8'd85},
      {8'd10, 8'd240, 8'd20, 8'd15}
    };
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // Reset defaults first, then each mode with a full-scale amount.
    foreach (directed[i]) send_pixel(directed[i]);
    drain();
    for (int m = 0; m < 4; m++) begin
      write_reg(REG_MODE, 17'(m));
      write_reg(REG_AMOUNT, (m == 1) ? 17'h1FFFF : 17'd65536);
      write_reg(REG_ALPHA, (m == 3) ? 17'd0 : 17'd255);
      for (int i = 0; i < 3; i++) send_pixel(directed[i * 3 + 1]);
      drain();
    end
    for (phase = 0; phase < 15; phase++) begin
      write_reg(REG_MODE, 17'($urandom_range(3)));
      write_reg(REG_AMOUNT, rand_amount());
      write_reg(REG_ALPHA, 17'($urandom_range(255)));
      if (phase == 4) begin
        src_idle_pct = 0; dst_idle_pct = 0;
      end else begin
        src_idle_pct = 33; dst_idle_pct = 33;
      end
      if (phase == 7) begin
        // Hold the receiver off long enough for the pipe to fill.
        @(negedge clk);
        hold_cycles <= 60;
        for (int i = 0; i < 50; i++) send_burst(rand_pixel());
      end else begin
        for (int i = 0; i < 50; i++) send_pixel(rand_pixel());
      end
      drain();
    end
    $display("Covered %0d pixels over all four modes, amount extremes and stall pressure.",
             board.checked);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+design
design/hslca_pkg.sv
design/hslca_rdiv.sv
design/hslca_rgb2hsl.sv
design/hslca_hsl2rgb.sv
design/hsl_color_adjust.sv
design/hslca_chk.sv
tb/sv/tb_top.sv
